[src/sfp_pkg.sv]
// Shared package for the small fast generator: command and register codes,
// round and retry counts, and the control bundle of the round datapath.
// Depends on nothing; imported by every module of the block.
package sfp_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned SEED_ROUNDS = 20;
  localparam int unsigned RETRY_LIMIT = 64;

  localparam logic [WORD_W-1:0] RESET_OUTPUT_MAX    = '1;
  localparam logic [WORD_W-1:0] RESET_SEED_CONSTANT = 64'd4058668781;

  localparam logic [CMD_W-1:0] CMD_RAW     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNIFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MAX    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_CONSTANT = 2'd1;

  // Control of the round datapath, driven by the sequencer.
  typedef struct packed {
    logic load;    // load the four words from the seed
    logic calc_e;  // first half of a round
    logic update;  // second half of a round
  } round_ctrl_t;

endpackage

[src/small_fast_prng_with_uniform_range.sv]
// Top level of the small fast generator with unbiased draws below a bound.
// Depends on sfp_pkg, sfp_round and sfp_mod.
//
//   Channel   Signals                                   Direction
//   --------  ----------------------------------------  ---------
//   config    cfg_we, cfg_index, cfg_data               in
//   command   in_valid, in_ready, cmd, seed_value,      in
//             upper_bound
//   result    out_valid, out_ready, random_value        out
//
// A round of the generator runs in two steps (subtract, then the add stage).
// A raw draw runs one round, a reseed SEED_ROUNDS rounds. A uniform draw with a
// bound of two or more runs a further round per rejected draw and runs the
// bit-serial remainder unit twice: once for the limit, once for the kept draw.
// After reset the block replays a reseed with seed zero, during which in_ready
// is low. One command is processed at a time; a new transaction is taken while
// the previous result still waits on the output.
module small_fast_prng_with_uniform_range
  import sfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       cmd,
  input  logic [WORD_W-1:0]      seed_value,
  input  logic [WORD_W-1:0]      upper_bound,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_W-1:0]      random_value
);

  typedef enum logic [2:0] {
    S_BOOT, S_IDLE, S_RND_E, S_RND_U, S_CHECK, S_LIMIT, S_REM, S_OUT
  } state_t;

  state_t            state;
  logic [CMD_W-1:0]  op;
  logic              booting;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] bound;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] limit;
  logic [WORD_W-1:0] output_max;
  logic [WORD_W-1:0] seed_constant;

  logic              accept;
  logic              small_bound;
  logic              draw_ok;
  logic              out_load;
  round_ctrl_t       round_ctrl;
  logic [WORD_W-1:0] load_seed;
  logic [WORD_W-1:0] d_next;
  logic              mod_start;
  logic [WORD_W-1:0] mod_dividend;
  logic [WORD_W-1:0] mod_divisor;
  logic              mod_busy;
  logic              mod_done;
  logic [WORD_W-1:0] mod_rem;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign small_bound = (upper_bound[WORD_W-1:1] == '0);
  // A draw is kept when it falls below the limit, or when the retries run out.
  assign draw_ok     = (r < limit) || (cnt == '0);
  // The output register takes a new result once the previous one is claimed.
  assign out_load    = (state == S_OUT) && (!out_valid || out_ready);

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_max    <= RESET_OUTPUT_MAX;
      seed_constant <= RESET_SEED_CONSTANT;
    end else if (cfg_we) begin
      if (cfg_index == REG_OUTPUT_MAX) begin
        output_max <= cfg_data;
      end else if (cfg_index == REG_SEED_CONSTANT) begin
        seed_constant <= cfg_data;
      end
    end
  end

  // Round datapath control. The boot state loads the words as a reseed with
  // seed zero would.
  always_comb begin
    round_ctrl.load   = (state == S_BOOT) || (accept && (cmd == CMD_RESEED));
    round_ctrl.calc_e = (state == S_RND_E);
    round_ctrl.update = (state == S_RND_U);
    load_seed         = (state == S_BOOT) ? '0 : seed_value;
  end

  // For a bound of two or more the remainder unit serves twice per uniform draw:
  // first for the rejection limit (output_max mod bound), then for the kept draw.
  always_comb begin
    if (state == S_IDLE) begin
      mod_start    = accept && (cmd == CMD_UNIFORM) && !small_bound;
      mod_dividend = output_max;
      mod_divisor  = upper_bound;
    end else begin
      mod_start    = (state == S_CHECK) && draw_ok;
      mod_dividend = r;
      mod_divisor  = bound;
    end
  end

  sfp_round u_round (
    .clk       (clk),
    .ctrl      (round_ctrl),
    .load_a    (seed_constant),
    .load_seed (load_seed),
    .d_next    (d_next)
  );

  sfp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Sequencer. The shared counter counts seeding rounds on a reseed and
  // remaining tries on a uniform draw.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      booting   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_BOOT: begin
          op      <= CMD_RESEED;
          cnt     <= CNT_W'(SEED_ROUNDS - 1);
          booting <= 1'b1;
          state   <= S_RND_E;
        end
        S_IDLE: begin
          if (accept) begin
            op    <= cmd;
            bound <= upper_bound;
            priority case (cmd)
              CMD_RAW: begin
                state <= S_RND_E;
              end
              CMD_UNIFORM: begin
                if (small_bound) begin
                  r     <= '0;
                  state <= S_OUT;
                end else begin
                  state <= S_LIMIT;
                end
              end
              CMD_RESEED: begin
                cnt   <= CNT_W'(SEED_ROUNDS - 1);
                state <= S_RND_E;
              end
              default: begin
                // Unused command: no state change, result zero.
                r     <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_RND_E: begin
          state <= S_RND_U;
        end
        S_RND_U: begin
          priority case (op)
            CMD_RESEED: begin
              if (cnt == '0) begin
                r <= '0;
                if (booting) begin
                  booting <= 1'b0;
                  state   <= S_IDLE;
                end else begin
                  state <= S_OUT;
                end
              end else begin
                cnt   <= cnt - CNT_W'(1);
                state <= S_RND_E;
              end
            end
            CMD_UNIFORM: begin
              r     <= d_next & output_max;
              state <= S_CHECK;
            end
            default: begin
              r     <= d_next & output_max;
              state <= S_OUT;
            end
          endcase
        end
        S_CHECK: begin
          if (draw_ok) begin
            state <= S_REM;
          end else begin
            cnt   <= cnt - CNT_W'(1);
            state <= S_RND_E;
          end
        end
        S_LIMIT: begin
          if (mod_done) begin
            limit <= output_max - mod_rem;
            cnt   <= CNT_W'(RETRY_LIMIT - 1);
            state <= S_RND_E;
          end
        end
        S_REM: begin
          if (mod_done) begin
            r     <= mod_rem;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Wait here only while the previous result is still unclaimed.
          if (out_load) begin
            random_value <= r;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The remainder unit reports completion only while the sequencer waits.
  assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_LIMIT) || (state == S_REM))
    else $error("remainder finished outside a waiting state");

  // The block never starts a command while the remainder unit is running.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mod_busy)
    else $error("ready while the remainder unit is busy");

  // Commands are processed one at a time.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready again straight after a transaction");

endmodule

[src/sfp_round.sv]
// Round datapath of the generator: holds the four state words and advances
// them by one round in two steps (calc_e, then update). Depends on sfp_pkg.
module sfp_round
  import sfp_pkg::*;
(
  input  logic              clk,
  input  round_ctrl_t       ctrl,
  input  logic [WORD_W-1:0] load_a,
  input  logic [WORD_W-1:0] load_seed,
  output logic [WORD_W-1:0] d_next
);

  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;
  logic [WORD_W-1:0] word_c;
  logic [WORD_W-1:0] word_d;
  logic [WORD_W-1:0] e;
  logic [WORD_W-1:0] a_next;

  assign a_next = word_b ^ {word_c[WORD_W-14:0], word_c[WORD_W-1:WORD_W-13]};
  assign d_next = e + a_next;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_a <= load_a;
      word_b <= load_seed;
      word_c <= load_seed;
      word_d <= load_seed;
    end else if (ctrl.calc_e) begin
      e <= word_a - {word_b[WORD_W-8:0], word_b[WORD_W-1:WORD_W-7]};
    end else if (ctrl.update) begin
      word_a <= a_next;
      word_b <= word_c + {word_d[WORD_W-38:0], word_d[WORD_W-1:WORD_W-37]};
      word_c <= word_d + e;
      word_d <= d_next;
    end
  end

endmodule

[src/sfp_mod.sv]
// Iterative remainder unit: restoring division, one quotient bit per cycle.
// Depends on sfp_pkg. The divisor must be at least two.
module sfp_mod
  import sfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [WORD_W-1:0] rem
);

  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] diff;

  assign rem_sh = {rem, dvd[WORD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[WORD_W-2:0], 1'b0};
        rem <= diff[WORD_W+1] ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
        cnt <= cnt + CNT_W'(1);
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for small_fast_prng_with_uniform_range: directed table,
// then random commands under several register settings. Depends on sfp_pkg and the RTL.
module tb;
  import sfp_pkg::*;

  // Codes the package does not name: the spare command and the spare register slots.
  localparam logic [CMD_W-1:0]       CMD_UNUSED   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  // Rotate amounts of one generator round.
  localparam int unsigned ROT_B = 7;
  localparam int unsigned ROT_C = 13;
  localparam int unsigned ROT_D = 37;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 225;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       cmd = CMD_RAW;
  logic [WORD_W-1:0]      seed_value = '0;
  logic [WORD_W-1:0]      upper_bound = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [WORD_W-1:0]      random_value;

  small_fast_prng_with_uniform_range u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .upper_bound  (upper_bound),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
  );

  // 10 ns clock, low phase first.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor keeps its own copy of the four generator words and of both
  // registers. It is only advanced when a command transaction is accepted, and
  // the registers are only changed while the block is idle, so the two stay in step.
  logic [WORD_W-1:0] gen_a, gen_b, gen_c, gen_d;
  logic [WORD_W-1:0] cur_max;
  logic [WORD_W-1:0] cur_seedk;

  // Expected values of the results still to come, oldest first.
  logic [WORD_W-1:0] draw_q [$];

  int errors      = 0;
  int n_results   = 0;
  int n_raw       = 0;
  int n_uniform   = 0;
  int n_reseed    = 0;
  int n_unused    = 0;
  int n_writes    = 0;
  int n_limit_hit = 0;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  // One round of the generator; returns the fourth word under the output mask.
  function automatic logic [WORD_W-1:0] gen_round();
    logic [WORD_W-1:0] e;
    e     = gen_a - rotl(gen_b, ROT_B);
    gen_a = gen_b ^ rotl(gen_c, ROT_C);
    gen_b = gen_c + rotl(gen_d, ROT_D);
    gen_c = gen_d + e;
    gen_d = e + gen_a;
    return gen_d & cur_max;
  endfunction

  function automatic void gen_reseed(input logic [WORD_W-1:0] s);
    gen_a = cur_seedk;
    gen_b = s;
    gen_c = s;
    gen_d = s;
    for (int i = 0; i < SEED_ROUNDS; i++) void'(gen_round());
  endfunction

  // Unbiased draw below the bound: reject draws at or above the largest
  // multiple of the bound, but give up after the retry limit and keep the last.
  function automatic logic [WORD_W-1:0] gen_below(input logic [WORD_W-1:0] bound);
    logic [WORD_W-1:0] limit;
    logic [WORD_W-1:0] r;
    bit                taken;
    r     = '0;
    taken = 1'b0;
    if (bound < 2) return '0;
    limit = cur_max - (cur_max % bound);
    for (int tries = 0; tries < RETRY_LIMIT; tries++) begin
      r = gen_round();
      if (r < limit) begin
        taken = 1'b1;
        break;
      end
    end
    if (!taken) n_limit_hit++;
    return r % bound;
  endfunction

  function automatic logic [WORD_W-1:0] predict_draw(input logic [CMD_W-1:0] c,
                                                     input logic [WORD_W-1:0] s,
                                                     input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] v;
    v = '0;
    case (c)
      CMD_RAW: begin
        v = gen_round();
        n_raw++;
      end
      CMD_UNIFORM: begin
        v = gen_below(b);
        n_uniform++;
      end
      CMD_RESEED: begin
        gen_reseed(s);
        n_reseed++;
      end
      default: begin
        n_unused++;
      end
    endcase
    return v;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 12);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // Bounds for the uniform draw: the small bounds, bounds beyond the maximum
  // (which exhaust the retries), the maximum itself, and spread values below it.
  function automatic logic [WORD_W-1:0] pick_bound();
    logic [WORD_W-1:0] b;
    int                r;
    b = {$urandom, $urandom} >> $urandom_range(WORD_W - 1);
    r = $urandom_range(99);
    if (r < 4) begin
      b = $urandom_range(1);
    end else if (r < 9) begin
      b = (cur_max == ALL_ONES) ? ALL_ONES : cur_max + 1 + (b % ~cur_max);
    end else if (r < 13) begin
      b = (cur_max < 2) ? 64'd2 : cur_max;
    end else if (cur_max >= 2) begin
      b = 2 + (b % (cur_max - 1));
    end else begin
      b = 2;
    end
    return b;
  endfunction

  // Offers one command transaction after the given gap and waits for it to be
  // taken. With no gap the valid stays high from the previous transaction.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] s,
                          input logic [WORD_W-1:0] b, input bit known,
                          input logic [WORD_W-1:0] want, input int gap);
    logic [WORD_W-1:0] pred;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    seed_value  <= s;
    upper_bound <= b;
    do @(posedge clk); while (!in_ready);
    pred = predict_draw(c, s, b);
    draw_q.push_back(known ? want : pred);
  endtask

  // Lowers valid and waits until every result has been collected, so that a
  // register can be changed with nothing in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (draw_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_OUTPUT_MAX) cur_max = data;
    else if (idx == REG_SEED_CONSTANT) cur_seedk = data;
    n_writes++;
  endtask

  // Result side. Outputs are sampled at the rising edge, before the block's own
  // updates of that edge land, and out_ready is driven for the next cycle. Once
  // the result count passes a mark, the receiver holds off for a long stretch so
  // that the block fills up and has to refuse command transactions.
  int                hold_left = 0;
  int                stall_left = 0;
  int                next_hold = 60;
  logic [WORD_W-1:0] rx_want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (draw_q.size() == 0) begin
        report($sformatf("result %0d (%h) with no transaction waiting",
                         n_results, random_value));
      end else begin
        rx_want = draw_q.pop_front();
        if (random_value !== rx_want)
          report($sformatf("result %0d: random_value %h, expected %h",
                           n_results, random_value, rx_want));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rst && n_results >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += 700;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ((n_results % 170) >= 35 && $urandom_range(99) < 20) begin
      // Outside the calm stretches the receiver stalls now and then.
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Directed table. Where the expected value is obvious it is typed in; the
  // other rows are checked against the predictor. Register rows write cfg_data
  // from the value column once the block has gone idle.
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CMD_W-1:0]       cmd;
    logic [CFG_INDEX_W-1:0] idx;
    logic [WORD_W-1:0]      value;
    logic [WORD_W-1:0]      bound;
    bit                     known;
    logic [WORD_W-1:0]      want;
  } row_t;

  localparam int DIR_ROWS = 29;

  row_t dir_rows [0:DIR_ROWS-1] = '{
    // First draws from the state the block builds after reset.
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b0, 64'd0},
    // Bounds of zero and one give zero and leave the state alone.
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'd1, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'd2, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'd3, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, ALL_ONES, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, TOP_BIT, 1'b0, 64'd0},
    // The spare command returns zero whatever its payload.
    '{ROW_ITEM, CMD_UNUSED,  REG_OUTPUT_MAX, ALL_ONES, ALL_ONES, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_RESEED,  REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_RESEED,  REG_OUTPUT_MAX, ALL_ONES, ALL_ONES, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'd10, 1'b0, 64'd0},
    // With a maximum of one every bounded draw is rejected until the retries run out.
    '{ROW_REG,  CMD_RAW,     REG_OUTPUT_MAX, 64'd1, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'd2, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, ALL_ONES, 1'b0, 64'd0},
    // A zero seed constant with a zero seed leaves an all-zero state, which stays zero.
    '{ROW_REG,  CMD_RAW,     REG_SEED_CONSTANT, 64'd0, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_RESEED,  REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b1, 64'd0},
    // Writes to the spare register slots must change nothing.
    '{ROW_REG,  CMD_RAW,     REG_UNUSED_2, ALL_ONES, 64'd0, 1'b0, 64'd0},
    '{ROW_REG,  CMD_RAW,     REG_UNUSED_3, ALL_ONES, 64'd0, 1'b0, 64'd0},
    '{ROW_REG,  CMD_RAW,     REG_OUTPUT_MAX, ALL_ONES, 64'd0, 1'b0, 64'd0},
    '{ROW_REG,  CMD_RAW,     REG_SEED_CONSTANT, ALL_ONES, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_RESEED,  REG_OUTPUT_MAX, 64'h0123_4567_89AB_CDEF, 64'd0, 1'b1, 64'd0},
    '{ROW_ITEM, CMD_RAW,     REG_OUTPUT_MAX, 64'd0, 64'd0, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0},
    '{ROW_ITEM, CMD_UNIFORM, REG_OUTPUT_MAX, 64'd0, TOP_BIT + 1, 1'b0, 64'd0}
  };

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin : main_seq
    logic [CMD_W-1:0]  c;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] b;
    int                r;
    int                gap;
    int                waited;

    // The block replays a reseed with seed zero after reset; the predictor does the same.
    cur_max   = RESET_OUTPUT_MAX;
    cur_seedk = RESET_SEED_CONSTANT;
    gen_reseed('0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The first command is only taken once the block has finished its own
    // reseed, so the register rows below never overlap it.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].bound,
                 dir_rows[i].known, dir_rows[i].want, pick_gap());
      end
    end

    // Random phases, each under its own register setting, the extremes included.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(REG_OUTPUT_MAX, ALL_ONES);
          write_reg(REG_SEED_CONSTANT, {$urandom, $urandom});
        end
        1: begin
          write_reg(REG_OUTPUT_MAX, 64'd1);
          write_reg(REG_SEED_CONSTANT, 64'd0);
        end
        2: begin
          write_reg(REG_OUTPUT_MAX, 64'hFF);
          write_reg(REG_SEED_CONSTANT, ALL_ONES);
        end
        3: begin
          write_reg(REG_OUTPUT_MAX, {$urandom, $urandom} | 64'd1);
          write_reg(REG_SEED_CONSTANT, {$urandom, $urandom});
          write_reg(REG_UNUSED_2, {$urandom, $urandom});
        end
        4: begin
          write_reg(REG_OUTPUT_MAX, ALL_ONES >> $urandom_range(WORD_W - 2, 1));
          write_reg(REG_SEED_CONSTANT, RESET_SEED_CONSTANT);
        end
        default: begin
          write_reg(REG_OUTPUT_MAX, ALL_ONES);
          write_reg(REG_SEED_CONSTANT, RESET_SEED_CONSTANT);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 40) c = CMD_RAW;
        else if (r < 85) c = CMD_UNIFORM;
        else if (r < 95) c = CMD_RESEED;
        else c = CMD_UNUSED;
        s = pick_word();
        b = (c == CMD_UNIFORM) ? pick_bound() : pick_word();
        // Every phase opens with a stretch of back-to-back transactions.
        gap = ((n % 160) < 30) ? 0 : pick_gap();
        send_cmd(c, s, b, 1'b0, '0, gap);
      end
    end
    in_valid <= 1'b0;

    // Wait for the outstanding results, then watch for stray ones a while longer.
    waited = 0;
    while (draw_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (draw_q.size() != 0)
      report($sformatf("%0d expected results never arrived", draw_q.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d command transactions: %0d raw, %0d bounded (%0d out of retries),",
             n_raw + n_uniform + n_reseed + n_unused, n_raw, n_uniform, n_limit_hit);
    $display("%0d reseeds, %0d spare; %0d register writes; %0d results checked, %0d mismatches.",
             n_reseed, n_unused, n_writes, n_results, errors);
    if (errors == 0) begin
      $display("small_fast_prng_with_uniform_range verification clean");
    end else begin
      $display("small_fast_prng_with_uniform_range verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including every bounded draw
  // exhausting its retries and every stall at its longest.
  initial begin
    #30000000;
    $display("Watchdog expired with %0d results outstanding", draw_q.size());
    $display("small_fast_prng_with_uniform_range verification failed");
    $finish;
  end

endmodule
